/* rtl/rsns_pkg.sv */
// ----------------------------------------------------------------------------
// rsns_pkg
// shared types, codes and helpers for the rank select and nearest slot block
// ----------------------------------------------------------------------------
package rsns_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned RANK_W    = 7;
	localparam int unsigned POS_W     = 6;
	localparam int unsigned DEPTH_DEF = 64;

	typedef enum logic [1:0] {
		ACT_APPEND  = 2'd0,
		ACT_CLEAR   = 2'd1,
		ACT_SELECT  = 2'd2,
		ACT_NEAREST = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	// per-cycle control from the sequencer to the scan unit
	typedef struct packed {
		logic start;     // clear accumulators for a new pass
		logic near;      // nearest pass, else select pass
		logic use_bound; // select pass: only values above bound count
		logic vld;       // read data valid this cycle
	} scan_ctl_t;

	// flip the sign bit so an unsigned compare orders like signed values
	function automatic logic [DATA_W-1:0] order_key(input logic [DATA_W-1:0] bits);
		return {~bits[DATA_W-1], bits[DATA_W-2:0]};
	endfunction

endpackage

/* rtl/rsns_ifs.sv */
// ----------------------------------------------------------------------------
// rsns channel interfaces
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
interface rsns_req_if;
	import rsns_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               action;
	logic signed [DATA_W-1:0] value;
	logic [RANK_W-1:0]        rank;

	modport source (output valid, action, value, rank, input ready);
	modport sink   (input valid, action, value, rank, output ready);
endinterface

interface rsns_rsp_if;
	import rsns_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] selected_value;
	logic [POS_W-1:0]         position;
	logic                     found;
	logic [1:0]               status;

	modport source (output valid, selected_value, position, found, status, input ready);
	modport sink   (input valid, selected_value, position, found, status, output ready);
endinterface

/* rtl/rsns_ram.sv */
// ----------------------------------------------------------------------------
// rsns_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module rsns_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/rsns_scan_unit.sv */
// ----------------------------------------------------------------------------
// rsns_scan_unit
// shared compare unit, folds one table entry per cycle into a running best
// ----------------------------------------------------------------------------
module rsns_scan_unit #(
	parameter int unsigned DEPTH = rsns_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rsns_pkg::scan_ctl_t               ctl,
	input  logic [$clog2(DEPTH)-1:0]          idx,
	input  logic [rsns_pkg::DATA_W-1:0]       data,
	input  logic [rsns_pkg::DATA_W-1:0]       bound,
	input  logic [$clog2(DEPTH+1)-1:0]        count,
	output logic [rsns_pkg::DATA_W-1:0]       best,
	output logic                              have,
	output logic [$clog2(DEPTH)-1:0]          pos
);
	import rsns_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] best_q;
	logic              have_q;
	logic [AW-1:0]     pos_q;
	logic [CW-1:0]     bestw_q;

	logic [DATA_W-1:0] key_d;
	logic              gt_bound;
	logic              lt_best;
	logic [CW-1:0]     half;
	logic [CW-1:0]     idx_ext;
	logic [CW-1:0]     weight;
	logic              hit;

	always_comb begin
		key_d    = order_key(data);
		gt_bound = key_d > order_key(bound);
		lt_best  = key_d < order_key(best_q);
		half     = count >> 1;
		idx_ext  = CW'(idx);
		weight   = (idx_ext <= half) ? idx_ext : (count - idx_ext);
		if (ctl.near) begin
			hit = (weight < bestw_q) && !gt_bound;
		end else begin
			hit = (!ctl.use_bound || gt_bound) && (!have_q || lt_best);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.start) begin
			have_q <= 1'b0;
		end else if (ctl.vld && hit) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			bestw_q <= half + CW'(1);
			pos_q   <= '0;
		end else if (ctl.vld && hit) begin
			best_q  <= data;
			bestw_q <= weight;
			pos_q   <= idx;
		end
	end

	assign best = best_q;
	assign have = have_q;
	assign pos  = pos_q;
endmodule

/* rtl/rank_select_and_nearest_slot_top.sv */
// ----------------------------------------------------------------------------
// rank_select_and_nearest_slot_top
// value table with k-th smallest distinct select and nearest-to-end search
// ----------------------------------------------------------------------------
//  channel | dir | fields                                      | accepted when
//  req     | in  | action, value, rank                         | valid & ready
//  rsp     | out | selected_value, position, found, status     | valid & ready
//
//  append, clear and queries on an empty table go from idle straight to the
//  output state. a nearest query takes one scan of N = entry count entries,
//  a select query P scans; each scan passes the scan, tail and eval states.
//  here P = min(k, distinct values + 1) with k = max(rank, 1), and the
//  extra pass is the one that finds nothing above the maximum. the scan
//  rate is set by the single ram read port and the shared compare unit.
//  req is ready only while the sequencer is idle; a result waiting in the
//  output register does not block the next item, only the next result.
//  reset clears the entry count and the handshake state; table contents stay
//  undefined until written.
// ----------------------------------------------------------------------------
module rank_select_and_nearest_slot_top #(
	parameter int unsigned DEPTH = rsns_pkg::DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rsns_req_if.sink   req,
	rsns_rsp_if.source rsp
);
	import rsns_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001, // waiting for an item
		S_SCAN = 5'b00010, // issuing table reads
		S_TAIL = 5'b00100, // last read data lands
		S_EVAL = 5'b01000, // end of pass decision
		S_OUT  = 5'b10000  // hand result to output register
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q;      // entries held
	logic [CW-1:0]     iss_q;      // next read index of the pass
	logic              rd_v_s1;    // read data valid
	logic [AW-1:0]     idx_s1;     // index of that data
	logic              near_q;     // nearest query in flight
	logic              first_q;    // select: minimum pass
	logic [RANK_W-1:0] steps_q;    // select: next-above passes left
	logic [DATA_W-1:0] bound_q;    // current select value or threshold
	logic [1:0]        kind_q;     // action of the item in flight
	status_t           res_st_q;

	logic                      out_v_q;
	logic [DATA_W-1:0]         sel_q;
	logic [POS_W-1:0]          pos_q;
	logic                      found_q;
	logic [1:0]                status_q;

	logic              accept;
	logic              start_pass;
	logic              ram_we;
	logic [DATA_W-1:0] rd_data;
	logic [DATA_W-1:0] best;
	logic              have;
	logic [AW-1:0]     best_pos;
	scan_ctl_t         ctl;
	logic              out_load;
	logic              full;

	assign accept   = req.valid && req.ready;
	assign full     = (cnt_q == CW'(DEPTH));
	assign ram_we   = accept && (req.action == ACT_APPEND) && !full;
	assign out_load = (state_q == S_OUT) && (!out_v_q || rsp.ready);

	// a new pass opens from idle on a query to a non-empty table, or from eval when more select steps remain
	always_comb begin
		start_pass = 1'b0;
		if (accept && (req.action == ACT_SELECT || req.action == ACT_NEAREST)
				&& cnt_q != '0) begin
			start_pass = 1'b1;
		end else if (state_q == S_EVAL && !near_q) begin
			if (first_q) begin
				start_pass = (steps_q != '0);
			end else begin
				start_pass = have && (steps_q != RANK_W'(1));
			end
		end
	end

	always_comb begin
		ctl.start     = start_pass;
		ctl.near      = near_q;
		ctl.use_bound = !first_q;
		ctl.vld       = rd_v_s1;
	end

	rsns_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata ($unsigned(req.value)),
		.raddr (iss_q[AW-1:0]),
		.rdata (rd_data)
	);

	rsns_scan_unit #(
		.DEPTH (DEPTH)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.idx    (idx_s1),
		.data   (rd_data),
		.bound  (bound_q),
		.count  (cnt_q),
		.best   (best),
		.have   (have),
		.pos    (best_pos)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == S_SCAN);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.action)
							ACT_APPEND: begin
								if (!full) begin
									cnt_q <= cnt_q + CW'(1);
								end
								state_q <= S_OUT;
							end
							ACT_CLEAR: begin
								cnt_q   <= '0;
								state_q <= S_OUT;
							end
							default: begin
								state_q <= start_pass ? S_SCAN : S_OUT;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (iss_q == cnt_q - CW'(1)) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= start_pass ? S_SCAN : S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item context and select stepping
	always_ff @(posedge clk) begin
		idx_s1 <= iss_q[AW-1:0];
		if (start_pass) begin
			iss_q <= '0;
		end else if (state_q == S_SCAN) begin
			iss_q <= iss_q + CW'(1);
		end
		if (accept) begin
			kind_q  <= req.action;
			near_q  <= (req.action == ACT_NEAREST);
			first_q <= 1'b1;
			bound_q <= $unsigned(req.value);
			steps_q <= (req.rank == '0) ? '0 : (req.rank - RANK_W'(1));
			if (req.action == ACT_APPEND && full) begin
				res_st_q <= ST_FULL;
			end else if ((req.action == ACT_SELECT || req.action == ACT_NEAREST)
					&& cnt_q == '0) begin
				res_st_q <= ST_EMPTY;
			end else begin
				res_st_q <= ST_OK;
			end
		end else if (state_q == S_EVAL && !near_q) begin
			if (first_q) begin
				bound_q <= best;
				first_q <= 1'b0;
			end else if (have) begin
				bound_q <= best;
				steps_q <= steps_q - RANK_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sel_q    <= '0;
			pos_q    <= '0;
			found_q  <= 1'b0;
			status_q <= res_st_q;
			if (res_st_q == ST_OK) begin
				if (kind_q == ACT_SELECT) begin
					sel_q <= bound_q;
				end else if (kind_q == ACT_NEAREST) begin
					found_q <= have;
					pos_q   <= POS_W'(best_pos);
				end
			end
		end
	end

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = out_v_q;
	assign rsp.selected_value = $signed(sel_q);
	assign rsp.position       = pos_q;
	assign rsp.found          = found_q;
	assign rsp.status         = status_q;
endmodule

/* tb/rank_select_and_nearest_slot_top_test.sv */
// ----------------------------------------------------------------------------
// rank_select_and_nearest_slot_top_test
// self-checking bench: a shadow value table predicts every select, nearest,
// append and clear item and the answers are compared field by field in order;
// random idling on both channels plus one long result hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import rsns_pkg::*;

typedef struct {
	logic signed [DATA_W-1:0] sel;
	logic [POS_W-1:0]         pos;
	logic                     found;
	status_t                  status;
} slot_answer_t;

class slot_table_tracker;
	logic signed [DATA_W-1:0] tbl [DEPTH_DEF];
	int unsigned              fill;
	slot_answer_t             answers_due [$];
	int unsigned              mismatches;

	function new();
		fill       = 0;
		mismatches = 0;
	endfunction

	task flag(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// work out the answer to an accepted item and keep the table in step
	function void note_item(input action_t act, input logic signed [DATA_W-1:0] val,
			input logic [RANK_W-1:0] rk);
		slot_answer_t             ans;
		logic signed [DATA_W-1:0] cur;
		logic signed [DATA_W-1:0] nxt;
		bit                       have;
		int unsigned              steps;
		int unsigned              half;
		int unsigned              best_w;
		int unsigned              w;
		ans = '{sel: '0, pos: '0, found: 1'b0, status: ST_OK};
		case (act)
			ACT_APPEND: begin
				if (fill >= DEPTH_DEF) ans.status = ST_FULL;
				else begin
					tbl[fill] = val;
					fill++;
				end
			end
			ACT_CLEAR: fill = 0;
			default: begin
				if (fill == 0) ans.status = ST_EMPTY;
				else if (act == ACT_SELECT) begin
					cur = tbl[0];
					for (int i = 1; i < fill; i++)
						if (tbl[i] < cur) cur = tbl[i];
					steps = (rk == 0) ? 0 : rk - 1;
					for (int s = 0; s < steps; s++) begin
						nxt  = cur;
						have = 1'b0;
						for (int i = 0; i < fill; i++)
							if (tbl[i] > cur && (!have || tbl[i] < nxt)) begin
								nxt  = tbl[i];
								have = 1'b1;
							end
						if (!have) break;
						cur = nxt;
					end
					ans.sel = cur;
				end else if (tbl[0] <= val) begin
					ans.found = 1'b1;
				end else begin
					half   = fill / 2;
					best_w = half + 1;
					for (int p = 0; p < fill; p++) begin
						w = (p <= half) ? p : fill - p;
						if (w < best_w && tbl[p] <= val) begin
							best_w    = w;
							ans.pos   = p[POS_W-1:0];
							ans.found = 1'b1;
						end
					end
				end
			end
		endcase
		answers_due.push_back(ans);
	endfunction

	task check_result(input logic signed [DATA_W-1:0] sel, input logic [POS_W-1:0] pos,
			input logic found, input logic [1:0] status);
		slot_answer_t exp;
		if (answers_due.size() == 0) begin
			flag("result item with nothing outstanding");
			return;
		end
		exp = answers_due.pop_front();
		if (sel !== exp.sel)
			flag($sformatf("selected_value %0d, want %0d", sel, exp.sel));
		if (pos !== exp.pos)
			flag($sformatf("position %0d, want %0d", pos, exp.pos));
		if (found !== exp.found)
			flag($sformatf("found %b, want %b", found, exp.found));
		if (status !== exp.status)
			flag($sformatf("status %0d, want %0d", status, exp.status));
	endtask
endclass

module rank_select_and_nearest_slot_top_test;

	// random part length and phase boundaries, counted in random items
	localparam int unsigned RAND_ITEMS  = 115;
	localparam int unsigned PHASE_B_AT  = 50;
	localparam int unsigned PHASE_C_AT  = 95;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN       = 50;
	// worst case is a 64-pass select on a full table
	localparam int unsigned LIMIT_NS    = 10_000_000;

	logic clk;
	logic arst_n;

	rsns_req_if req_ch ();
	rsns_rsp_if rsp_ch ();

	rank_select_and_nearest_slot_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	slot_table_tracker tracker = new();

	int unsigned src_idle_pct = 29;
	int unsigned snk_idle_pct = 88;
	int unsigned items_sent   = 0;
	// main process asks for a hold-off, the result side serves it
	int unsigned hold_asked   = 0;
	int unsigned hold_served  = 0;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// every block input gets a known value from time zero
	initial begin
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.action  = ACT_CLEAR;
		req_ch.value   = '0;
		req_ch.rank    = '0;
		rsp_ch.ready   = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#(LIMIT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	// result side: random stalls, plus one long hold-off counted here so the
	// output register fills and the block stops taking request items
	initial begin : result_side
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_asked != hold_served) begin
				hold_left = HOLD_CYCLES;
				hold_served++;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// both channels sampled on the edge where the handshake happens
	always @(posedge clk) begin
		if (arst_n && req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
			tracker.note_item(action_t'(req_ch.action), req_ch.value, req_ch.rank);
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			tracker.check_result(rsp_ch.selected_value, rsp_ch.position,
				rsp_ch.found, rsp_ch.status);
	end

	// offer one item, idling first now and then; valid stays high on return
	// so back-to-back items never lower and raise it in the same step
	task automatic send_item(input action_t act, input logic signed [DATA_W-1:0] val,
			input logic [RANK_W-1:0] rk);
		if ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		req_ch.valid  <= 1'b1;
		req_ch.action <= act;
		req_ch.value  <= val;
		req_ch.rank   <= rk;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		items_sent++;
	endtask

	// value mix: narrow band for duplicates, full range, or the extremes
	function automatic logic signed [DATA_W-1:0] pick_value(input int unsigned mode);
		case (mode)
			0: return int'($urandom_range(16)) - 8;
			1: return $urandom;
			default: begin
				case ($urandom_range(3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return '0;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	initial begin : stimulus
		int unsigned              directed_cnt;
		int unsigned              n_app;
		int unsigned              n_q;
		int unsigned              vmode;
		int unsigned              lim;
		bit                       first_seq;
		logic [RANK_W-1:0]        rk;
		logic signed [DATA_W-1:0] thr;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// queries on an empty table after reset
		send_item(ACT_SELECT, 32'sd3, 7'd1);
		send_item(ACT_NEAREST, 32'sd0, 7'd0);
		// extremes and a duplicate
		send_item(ACT_APPEND, 32'sd5, 7'd64);
		send_item(ACT_APPEND, 32'h7fff_ffff, 7'd0);
		send_item(ACT_APPEND, 32'h8000_0000, 7'd0);
		send_item(ACT_APPEND, 32'sd5, 7'd0);
		send_item(ACT_APPEND, -32'sd1, 7'd0);
		// rank zero acts as one, a middle rank, rank past the distinct count
		send_item(ACT_SELECT, 32'sd0, 7'd0);
		send_item(ACT_SELECT, 32'sd0, 7'd1);
		send_item(ACT_SELECT, 32'sd0, 7'd3);
		send_item(ACT_SELECT, 32'h7fff_ffff, 7'd64);
		// head qualifies, then only the minimum qualifies
		send_item(ACT_NEAREST, 32'sd5, 7'd0);
		send_item(ACT_NEAREST, -32'sd2, 7'd0);
		send_item(ACT_NEAREST, 32'h8000_0000, 7'd127 >> 1);
		send_item(ACT_CLEAR, 32'hffff_ffff, 7'd64);
		// two positions at equal weight from either end, earlier must win
		send_item(ACT_APPEND, 32'sd10, 7'd0);
		send_item(ACT_APPEND, 32'sd3, 7'd0);
		send_item(ACT_APPEND, 32'sd20, 7'd0);
		send_item(ACT_APPEND, 32'sd3, 7'd0);
		send_item(ACT_NEAREST, 32'sd5, 7'd0);
		// nothing at or below the threshold
		send_item(ACT_NEAREST, 32'sd2, 7'd0);
		send_item(ACT_NEAREST, 32'sd10, 7'd0);
		send_item(ACT_SELECT, 32'sd0, 7'd2);
		directed_cnt = items_sent;

		// ---- random part: clear, fill, query, with some noise ----
		first_seq = 1'b1;
		while (items_sent < directed_cnt + RAND_ITEMS) begin
			if (items_sent >= directed_cnt + PHASE_C_AT && src_idle_pct != 0) begin
				// no idling from here on; the long hold-off lands in this phase
				src_idle_pct = 0;
				snk_idle_pct = 0;
				hold_asked++;
			end else if (items_sent >= directed_cnt + PHASE_B_AT && src_idle_pct == 29) begin
				src_idle_pct = 88;
				snk_idle_pct = 29;
			end

			// mostly start from an empty table, sometimes keep growing
			if (first_seq || $urandom_range(9) != 0)
				send_item(ACT_CLEAR, $urandom, RANK_W'($urandom_range(64)));

			// first sequence overfills the table to hit the dropped append case
			if (first_seq) n_app = DEPTH_DEF + 2;
			else if ($urandom_range(11) == 0) n_app = $urandom_range(70, 40);
			else n_app = $urandom_range(16, 1);
			first_seq = 1'b0;
			vmode = $urandom_range(2);

			for (int i = 0; i < n_app; i++) begin
				send_item(ACT_APPEND, pick_value(vmode), RANK_W'($urandom_range(64)));
				if ($urandom_range(19) == 0)
					send_item(action_t'($urandom_range(3)), $urandom,
						RANK_W'($urandom_range(64)));
			end

			n_q = $urandom_range(6, 1);
			for (int q = 0; q < n_q; q++) begin
				if ($urandom_range(1) == 0) begin
					lim = (tracker.fill + 2 > 64) ? 64 : tracker.fill + 2;
					case ($urandom_range(5))
						0: rk = '0;
						1: rk = 7'd64;
						default: rk = RANK_W'($urandom_range(lim, 1));
					endcase
					send_item(ACT_SELECT, $urandom, rk);
				end else begin
					// threshold near a stored value, or anywhere
					if (tracker.fill != 0 && $urandom_range(1) == 0)
						thr = tracker.tbl[$urandom_range(tracker.fill - 1)]
							+ int'($urandom_range(2)) - 1;
					else
						thr = pick_value($urandom_range(2));
					send_item(ACT_NEAREST, thr, RANK_W'($urandom_range(64)));
				end
			end
		end

		// ---- drain ----
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.answers_due.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (tracker.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
rtl/rsns_pkg.sv
rtl/rsns_ifs.sv
rtl/rsns_ram.sv
rtl/rsns_scan_unit.sv
rtl/rank_select_and_nearest_slot_top.sv
tb/rank_select_and_nearest_slot_top_test.sv
